// ----- hdl/ics_pkg.sv -----
// Shared widths, state encodings and helpers for the image cosine similarity unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package ics_pkg;

  // Pixel layout: four bytes per pixel, one reference and one candidate pixel per beat
  localparam int BYTE_W    = 8;
  localparam int PIX_BYTES = 4;
  localparam int PIX_W     = BYTE_W * PIX_BYTES;
  localparam int CH_W      = $clog2(PIX_BYTES);
  localparam int SQ_W      = 2 * BYTE_W;

  // Accumulators and result format
  localparam int ACC_W     = 48;
  localparam int FRAC_BITS = 16;
  localparam int SIM_W     = FRAC_BITS + 1;

  // Ratio solver widths: product of the two norms, and the widest trial value
  localparam int PROD_W    = 2 * ACC_W;
  localparam int WIDE_W    = PROD_W + 2 * SIM_W;
  localparam int BIT_W     = $clog2(SIM_W);
  localparam int CNT_W     = $clog2(ACC_W);

  // Stream data widths, padded to whole bytes
  localparam int IN_W      = 2 * PIX_W;
  localparam int OUT_W     = ((SIM_W + 1 + 7) / 8) * 8;

  localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_BITS;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_NORM,
    ST_SOLVE,
    ST_EMIT
  } top_state_t;

  // Ratio solver sequencer
  typedef enum logic [2:0] {
    SV_IDLE,
    SV_MUL_P,
    SV_MUL_D,
    SV_TERM,
    SV_TRIAL,
    SV_COMMIT,
    SV_DONE
  } sv_state_t;

  // Clamp the solver quotient to one in Q1.FRAC_BITS
  function automatic logic [SIM_W-1:0] clamp_sim(input logic [SIM_W-1:0] q);
    clamp_sim = (q > SIM_ONE) ? SIM_ONE : q;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/image_cosine_similarity_unit.sv -----
// Image cosine similarity unit, top level: stream handshake, channel sequencer,
// output register. Instantiates ics_mac and ics_solver; uses ics_pkg.
//
//  port group  dir  width  contents
//  s_axis_*    in   64+1   pixel pair beat, tlast marks the final pair of an image
//  m_axis_*    out  24     one result beat per image
//
// A pixel pair is accepted in one beat and then walks the byte MAC, one channel per
// cycle. A beat with tlast adds a norm check and, when both norms are nonzero, a
// ratio solver run (two 48-step shift-add products, then a term, trial and commit
// step per quotient bit on the shared adder), then the load of the output register.
// The output register lets the next image
// start while a result waits; a second result waits until the first is taken.
// Reset is synchronous and clears the accumulators, the state machines and the output valid.
`default_nettype none

module image_cosine_similarity_unit
  import ics_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] ref_c0, [15:8] ref_c1, [23:16] ref_c2, [31:24] ref_c3,
  // [39:32] cand_c0, [47:40] cand_c1, [55:48] cand_c2, [63:56] cand_c3
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [16:0] similarity, [17] norm_zero, [23:18] zero
  output logic      [OUT_W-1:0] m_axis_tdata
);

  top_state_t state, state_next;

  logic [IN_W-1:0]   pix;
  logic              last_q;
  logic [CH_W-1:0]   ch, ch_next;
  logic [SIM_W-1:0]  res_sim, res_sim_next;
  logic              res_nz, res_nz_next;
  logic              accept;
  logic              mac_en;
  logic              acc_clr;
  logic              solve_start;
  logic              out_load;
  logic              solver_done;
  logic [SIM_W-1:0]  solver_q;
  logic [BYTE_W-1:0] ref_byte;
  logic [BYTE_W-1:0] cand_byte;
  logic [ACC_W-1:0]  dot_sum;
  logic [ACC_W-1:0]  ref_square_sum;
  logic [ACC_W-1:0]  cand_square_sum;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign ref_byte  = pix[ch * BYTE_W +: BYTE_W];
  assign cand_byte = pix[PIX_W + ch * BYTE_W +: BYTE_W];

  ics_mac u_mac (
    .clk             (clk),
    .rst             (rst),
    .en              (mac_en),
    .clr             (acc_clr),
    .ref_byte        (ref_byte),
    .cand_byte       (cand_byte),
    .dot_sum         (dot_sum),
    .ref_square_sum  (ref_square_sum),
    .cand_square_sum (cand_square_sum)
  );

  ics_solver u_solver (
    .clk   (clk),
    .rst   (rst),
    .start (solve_start),
    .dot   (dot_sum),
    .ra    (ref_square_sum),
    .cb    (cand_square_sum),
    .done  (solver_done),
    .q     (solver_q)
  );

  // Sequencer: accept, walk the channels, then finish the image on tlast
  always_comb begin
    state_next    = state;
    ch_next       = ch;
    res_sim_next  = res_sim;
    res_nz_next   = res_nz;
    s_axis_tready = 1'b0;
    mac_en        = 1'b0;
    acc_clr       = 1'b0;
    solve_start   = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ch_next    = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_en  = 1'b1;
        ch_next = ch + CH_W'(1);
        if (ch == CH_W'(PIX_BYTES - 1)) begin
          state_next = last_q ? ST_NORM : ST_IDLE;
        end
      end
      ST_NORM: begin
        if (ref_square_sum == '0 || cand_square_sum == '0) begin
          res_sim_next = '0;
          res_nz_next  = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          solve_start = 1'b1;
          state_next  = ST_SOLVE;
        end
      end
      ST_SOLVE: begin
        if (solver_done) begin
          res_sim_next = clamp_sim(solver_q);
          res_nz_next  = 1'b0;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          acc_clr    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Beat capture, channel index and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pix    <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    ch      <= ch_next;
    res_sim <= res_sim_next;
    res_nz  <= res_nz_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_W'({res_nz, res_sim});
    end
  end

  // Checks
  a_load_needs_last: assert property (@(posedge clk) disable iff (rst)
    out_load |-> last_q)
    else $error("result loaded for a beat without tlast");

  a_done_in_solve: assert property (@(posedge clk) disable iff (rst)
    solver_done |-> state == ST_SOLVE)
    else $error("solver finished outside the solve state");

  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[SIM_W]) |-> m_axis_tdata[SIM_W-1:0] == '0)
    else $error("zero norm result with nonzero similarity");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[SIM_W-1:0] <= SIM_ONE)
    else $error("similarity above one");

endmodule

`default_nettype wire

// ----- hdl/ics_mac.sv -----
// Byte multiply-accumulate unit: one channel of a pixel pair per cycle while enabled into three
// saturating 48-bit sums (dot product, reference squares, candidate squares). Uses ics_pkg.
`default_nettype none

module ics_mac
  import ics_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              clr,
  input  wire logic [BYTE_W-1:0] ref_byte,
  input  wire logic [BYTE_W-1:0] cand_byte,
  output logic      [ACC_W-1:0]  dot_sum,
  output logic      [ACC_W-1:0]  ref_square_sum,
  output logic      [ACC_W-1:0]  cand_square_sum
);

  logic [SQ_W-1:0]  prod_rc;
  logic [SQ_W-1:0]  prod_rr;
  logic [SQ_W-1:0]  prod_cc;
  logic [ACC_W:0]   dot_add;
  logic [ACC_W:0]   ref_add;
  logic [ACC_W:0]   cand_add;
  logic [ACC_W-1:0] dot_sum_next;
  logic [ACC_W-1:0] ref_square_sum_next;
  logic [ACC_W-1:0] cand_square_sum_next;

  // Three byte products for the selected channel
  assign prod_rc = SQ_W'(ref_byte) * SQ_W'(cand_byte);
  assign prod_rr = SQ_W'(ref_byte) * SQ_W'(ref_byte);
  assign prod_cc = SQ_W'(cand_byte) * SQ_W'(cand_byte);

  // Add with carry out; a carry pins the sum at all ones
  assign dot_add  = {1'b0, dot_sum} + (ACC_W + 1)'(prod_rc);
  assign ref_add  = {1'b0, ref_square_sum} + (ACC_W + 1)'(prod_rr);
  assign cand_add = {1'b0, cand_square_sum} + (ACC_W + 1)'(prod_cc);

  always_comb begin
    dot_sum_next         = dot_add[ACC_W]  ? '1 : dot_add[ACC_W-1:0];
    ref_square_sum_next  = ref_add[ACC_W]  ? '1 : ref_add[ACC_W-1:0];
    cand_square_sum_next = cand_add[ACC_W] ? '1 : cand_add[ACC_W-1:0];
  end

  // Accumulators: cleared after each image result
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      dot_sum         <= '0;
      ref_square_sum  <= '0;
      cand_square_sum <= '0;
    end else if (en) begin
      dot_sum         <= dot_sum_next;
      ref_square_sum  <= ref_square_sum_next;
      cand_square_sum <= cand_square_sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ics_solver.sv -----
// Ratio solver: finds the largest q with q^2 * ra * cb <= dot^2 * 2^(2*FRAC_BITS)
// using one shared wide adder under a small sequencer. Uses ics_pkg.
`default_nettype none

module ics_solver
  import ics_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] dot,
  input  wire logic [ACC_W-1:0] ra,
  input  wire logic [ACC_W-1:0] cb,
  output logic                  done,
  output logic      [SIM_W-1:0] q
);

  sv_state_t state, state_next;

  // Datapath registers
  logic [WIDE_W-1:0] s, s_next;       // product / trial accumulator
  logic [PROD_W-1:0] mc, mc_next;     // shifting multiplicand
  logic [ACC_W-1:0]  mp, mp_next;     // shifting multiplier
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [PROD_W-1:0] p, p_next;       // ra * cb
  logic [PROD_W-1:0] d, d_next;       // dot^2
  logic [WIDE_W-1:0] x, x_next;       // q^2 * p
  logic [WIDE_W-1:0] u, u_next;       // q * p << (b+1)
  logic [WIDE_W-1:0] v, v_next;       // p << 2b
  logic [SIM_W-1:0]  q_next;
  logic [BIT_W-1:0]  b, b_next;

  // Shared adder and its operand select
  logic [WIDE_W-1:0] opa;
  logic [WIDE_W-1:0] opb;
  logic [WIDE_W-1:0] sum;
  logic [WIDE_W-1:0] dsh;
  logic              fits;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      SV_MUL_P, SV_MUL_D: begin
        opa = s;
        opb = mp[0] ? WIDE_W'(mc) : '0;
      end
      SV_TERM: begin
        opa = u;
        opb = v;
      end
      SV_TRIAL: begin
        opa = x;
        opb = s;
      end
      SV_COMMIT: begin
        opa = u;
        opb = v << 1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign sum  = opa + opb;
  assign dsh  = WIDE_W'(d) << (2 * FRAC_BITS);
  assign fits = (s <= dsh);

  // Sequencer: two shift-add products, then one quotient bit per term, trial and commit pass
  always_comb begin
    state_next = state;
    s_next     = s;
    mc_next    = mc;
    mp_next    = mp;
    cnt_next   = cnt;
    p_next     = p;
    d_next     = d;
    x_next     = x;
    u_next     = u;
    v_next     = v;
    q_next     = q;
    b_next     = b;
    done       = 1'b0;
    unique case (state)
      SV_IDLE: begin
        if (start) begin
          s_next     = '0;
          mc_next    = PROD_W'(ra);
          mp_next    = cb;
          cnt_next   = '0;
          state_next = SV_MUL_P;
        end
      end
      SV_MUL_P: begin
        s_next   = sum;
        mc_next  = mc << 1;
        mp_next  = mp >> 1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(ACC_W - 1)) begin
          p_next     = sum[PROD_W-1:0];
          s_next     = '0;
          mc_next    = PROD_W'(dot);
          mp_next    = dot;
          cnt_next   = '0;
          state_next = SV_MUL_D;
        end
      end
      SV_MUL_D: begin
        s_next   = sum;
        mc_next  = mc << 1;
        mp_next  = mp >> 1;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(ACC_W - 1)) begin
          d_next     = sum[PROD_W-1:0];
          x_next     = '0;
          u_next     = '0;
          v_next     = WIDE_W'(p) << (2 * FRAC_BITS);
          q_next     = '0;
          b_next     = BIT_W'(FRAC_BITS);
          state_next = SV_TERM;
        end
      end
      SV_TERM: begin
        // cross term plus square term of the trial bit
        s_next     = sum;
        state_next = SV_TRIAL;
      end
      SV_TRIAL: begin
        s_next     = sum;
        state_next = SV_COMMIT;
      end
      SV_COMMIT: begin
        if (fits) begin
          x_next    = s;
          u_next    = sum >> 1;
          q_next[b] = 1'b1;
        end else begin
          u_next = u >> 1;
        end
        v_next = v >> 2;
        if (b == '0) begin
          state_next = SV_DONE;
        end else begin
          b_next     = b - BIT_W'(1);
          state_next = SV_TERM;
        end
      end
      SV_DONE: begin
        done       = 1'b1;
        state_next = SV_IDLE;
      end
      default: begin
        state_next = SV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    s   <= s_next;
    mc  <= mc_next;
    mp  <= mp_next;
    cnt <= cnt_next;
    p   <= p_next;
    d   <= d_next;
    x   <= x_next;
    u   <= u_next;
    v   <= v_next;
    q   <= q_next;
    b   <= b_next;
  end

endmodule

`default_nettype wire
